### design/rpwu_pkg.sv
// ----------------------------------------------------------------------------
// Rprop weight update package
// Field widths, codes, register indexes and the stored entry layout shared
// by the weight update core and its memory.
// ----------------------------------------------------------------------------
package rpwu_pkg;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int STEP_W  = 31;
  localparam int FACT_W  = 16;
  localparam int FRAC_SH = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Item kinds carried on tuser.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Stored gradient sign codes.
  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INCREASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECREASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INI = 3'd4;

  localparam logic [FACT_W-1:0] INCREASE_RST = 16'd19661;
  localparam logic [FACT_W-1:0] DECREASE_RST = 16'd8192;
  localparam logic [STEP_W-1:0] STEP_MIN_RST = 31'd0;
  localparam logic [STEP_W-1:0] STEP_MAX_RST = 31'd3276800;
  localparam logic [STEP_W-1:0] STEP_INI_RST = 31'd6554;

  localparam logic [STEP_W-1:0] STEP_SAT = '1;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_GROW,
    KIND_SHRINK,
    KIND_HOLD
  } kind_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] weight;
    logic        [STEP_W-1:0] step;
    logic signed [VAL_W-1:0] last_move;
    logic        [1:0]        sign;
  } entry_t;

endpackage

### design/rprop_weight_update_core.sv
// ----------------------------------------------------------------------------
// Rprop weight update core
// Per-weight Rprop update with weight backtracking, one stored entry per
// weight, fed by a stream of load and gradient items.
// ----------------------------------------------------------------------------
// The core takes one item per clock when no same-entry hazard or result
// back-pressure holds the input, and passes it through a memory read, a step
// multiply, a clamp and move select, and a saturating weight add, each in a
// stage of its own. The entry store has one read and one write port, so an
// item that addresses the same entry as one of the three items still in the
// update stages waits at the input until that item has been written back,
// which takes longer while the result side is stalled. Entries
// are undefined after reset and must be loaded before their first update; no
// clearing pass runs. Neither the input nor the configuration channel is
// ready during reset. Configuration writes are taken at any other time and
// belong in idle periods.
module rprop_weight_update_core #(
  parameter int NUM_WEIGHTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // weight_index[9:0], value[41:10], zero fill
  input  logic        s_axis_tuser,  // op
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // result_index[9:0], new_weight[41:10],
                                     // new_step[72:42], zero fill
);
  import rpwu_pkg::*;

  localparam int IDX_LIMIT = 2 ** IDX_W;
  localparam int DEPTH = (NUM_WEIGHTS < IDX_LIMIT) ? NUM_WEIGHTS : IDX_LIMIT;
  localparam int AW = $clog2(DEPTH);
  localparam logic [IDX_W:0] DEPTH_L = DEPTH[IDX_W:0];

  // Configuration registers.
  logic [FACT_W-1:0] increase_factor;
  logic [FACT_W-1:0] decrease_factor;
  logic [STEP_W-1:0] step_minimum;
  logic [STEP_W-1:0] step_maximum;
  logic [STEP_W-1:0] step_initial;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      increase_factor <= INCREASE_RST;
      decrease_factor <= DECREASE_RST;
      step_minimum    <= STEP_MIN_RST;
      step_maximum    <= STEP_MAX_RST;
      step_initial    <= STEP_INI_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INCREASE: increase_factor <= cfg_data[FACT_W-1:0];
        REG_DECREASE: decrease_factor <= cfg_data[FACT_W-1:0];
        REG_STEP_MIN: step_minimum    <= cfg_data[STEP_W-1:0];
        REG_STEP_MAX: step_maximum    <= cfg_data[STEP_W-1:0];
        REG_STEP_INI: step_initial    <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [IDX_W-1:0]        in_idx;
  logic signed [VAL_W-1:0] in_val;
  logic                    in_fire;
  logic                    hazard;

  assign in_idx = s_axis_tdata[IDX_W-1:0];
  assign in_val = s_axis_tdata[IDX_W +: VAL_W];

  // Pipeline flow control: each stage moves when the next one is free.
  logic s1_valid, s2_valid, s3_valid, m_valid;
  logic out_free, s3_ready, s2_ready, s1_ready;

  assign out_free = !m_valid || m_axis_tready;
  assign s3_ready = !s3_valid || out_free;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;

  logic [IDX_W-1:0] s1_idx, s2_idx, s3_idx;

  assign hazard = (s1_valid && s1_idx == in_idx) ||
                  (s2_valid && s2_idx == in_idx) ||
                  (s3_valid && s3_idx == in_idx);

  assign s_axis_tready = !rst && s1_ready && !hazard;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Entry store.
  entry_t     rd_entry;
  entry_t     wr_entry;
  logic       wr_en;
  logic [AW-1:0] wr_addr;

  rpwu_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_idx[AW-1:0]),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry)
  );

  // Stage 1: entry read back, sign compare and choice of factor.
  logic                    s1_op;
  logic signed [VAL_W-1:0] s1_val;
  logic                    s1_inr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op  <= s_axis_tuser;
      s1_idx <= in_idx;
      s1_val <= in_val;
      s1_inr <= ({1'b0, in_idx} < DEPTH_L);
    end
  end

  logic        g_pos, g_neg, o_pos, o_neg;
  kind_t       s1_kind;
  logic [1:0]  s1_sign;
  logic [FACT_W-1:0] s1_factor;

  assign g_pos = !s1_val[VAL_W-1] && (s1_val != '0);
  assign g_neg = s1_val[VAL_W-1];
  assign o_pos = (rd_entry.sign == SIGN_POS);
  assign o_neg = rd_entry.sign[1];

  always_comb begin
    if (s1_op == OP_LOAD) begin
      s1_kind = KIND_LOAD;
    end else if ((o_pos && g_pos) || (o_neg && g_neg)) begin
      s1_kind = KIND_GROW;
    end else if ((o_pos && g_neg) || (o_neg && g_pos)) begin
      s1_kind = KIND_SHRINK;
    end else begin
      s1_kind = KIND_HOLD;
    end
  end

  always_comb begin
    case (s1_kind)
      KIND_GROW: s1_sign = g_pos ? SIGN_POS : SIGN_NEG;
      KIND_HOLD: s1_sign = g_pos ? SIGN_POS : (g_neg ? SIGN_NEG : SIGN_ZERO);
      default:   s1_sign = SIGN_ZERO;
    endcase
  end

  assign s1_factor = (s1_kind == KIND_GROW) ? increase_factor : decrease_factor;

  logic [STEP_W-1:0] s2_scaled;

  rpwu_scaler u_scaler (
    .clk    (clk),
    .en     (s2_ready),
    .step   (rd_entry.step),
    .factor (s1_factor),
    .scaled (s2_scaled)
  );

  // Stage 2: step clamp and move select.
  kind_t                   s2_kind;
  logic                    s2_inr;
  logic                    s2_gpos, s2_gneg;
  logic signed [VAL_W-1:0] s2_base;
  logic [STEP_W-1:0]       s2_step;
  logic signed [VAL_W-1:0] s2_last;
  logic [1:0]              s2_sign;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_kind <= s1_kind;
      s2_idx  <= s1_idx;
      s2_inr  <= s1_inr;
      s2_gpos <= g_pos;
      s2_gneg <= g_neg;
      s2_base <= (s1_op == OP_LOAD) ? s1_val : rd_entry.weight;
      s2_step <= rd_entry.step;
      s2_last <= rd_entry.last_move;
      s2_sign <= s1_sign;
    end
  end

  logic [STEP_W-1:0]       grow_step, shrink_step, s2_step_next;
  logic signed [VAL_W-1:0] step_pos, s2_move;

  assign grow_step   = (s2_scaled > step_maximum) ? step_maximum : s2_scaled;
  assign shrink_step = (s2_scaled < step_minimum) ? step_minimum : s2_scaled;

  always_comb begin
    case (s2_kind)
      KIND_LOAD:   s2_step_next = step_initial;
      KIND_GROW:   s2_step_next = grow_step;
      KIND_SHRINK: s2_step_next = shrink_step;
      default:     s2_step_next = s2_step;
    endcase
  end

  assign step_pos = VAL_W'(s2_step_next);

  // Backtracking undoes the stored move, which never is the most negative code.
  always_comb begin
    case (s2_kind)
      KIND_SHRINK: s2_move = -s2_last;
      KIND_GROW,
      KIND_HOLD: begin
        if (s2_gpos) begin
          s2_move = -step_pos;
        end else if (s2_gneg) begin
          s2_move = step_pos;
        end else begin
          s2_move = '0;
        end
      end
      default: s2_move = '0;
    endcase
  end

  // Stage 3: saturating weight add and write back.
  logic                    s3_inr;
  logic signed [VAL_W-1:0] s3_base, s3_move;
  logic [STEP_W-1:0]       s3_step;
  logic [1:0]              s3_sign;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_idx  <= s2_idx;
      s3_inr  <= s2_inr;
      s3_base <= s2_base;
      s3_move <= s2_move;
      s3_step <= s2_step_next;
      s3_sign <= s2_sign;
    end
  end

  logic signed [VAL_W:0]   sum;
  logic signed [VAL_W-1:0] s3_weight;

  assign sum = {s3_base[VAL_W-1], s3_base} + {s3_move[VAL_W-1], s3_move};

  always_comb begin
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      s3_weight = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      s3_weight = sum[VAL_W-1:0];
    end
  end

  assign wr_en   = s3_valid && out_free && s3_inr;
  assign wr_addr = s3_idx[AW-1:0];
  assign wr_entry = '{weight: s3_weight, step: s3_step, last_move: s3_move,
                      sign: s3_sign};

  // Output register.
  logic [IDX_W-1:0]        m_idx;
  logic signed [VAL_W-1:0] m_weight;
  logic [STEP_W-1:0]       m_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_free) begin
      m_valid <= s3_valid;
    end
  end

  // An index beyond the store reports zero weight and step.
  always_ff @(posedge clk) begin
    if (out_free) begin
      m_idx    <= s3_idx;
      m_weight <= s3_inr ? s3_weight : '0;
      m_step   <= s3_inr ? s3_step : '0;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'b0, m_step, m_weight, m_idx};

`ifndef SYNTHESIS
  // No two items in the update stages may address the same entry.
  a_s1_s2_distinct: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid) |-> (s1_idx != s2_idx))
    else $error("stages one and two hold the same entry");

  a_s2_s3_distinct: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s3_valid) |-> (s2_idx != s3_idx))
    else $error("stages two and three hold the same entry");

  a_s1_s3_distinct: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s3_valid) |-> (s1_idx != s3_idx))
    else $error("stages one and three hold the same entry");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (s1_valid && s1_idx == $past(in_idx)))
    else $error("accepted beat did not reach stage one");
`endif

endmodule

### design/rpwu_store.sv
// ----------------------------------------------------------------------------
// Rprop weight entry store
// One write port and one read port with registered read data; each entry
// holds weight, step size, last move and gradient sign.
// ----------------------------------------------------------------------------
module rpwu_store #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output rpwu_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  rpwu_pkg::entry_t wr_data
);
  import rpwu_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read register holds its data while the first stage is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/rpwu_scaler.sv
// ----------------------------------------------------------------------------
// Rprop step scaler
// Registered step by factor product, truncated by the Q2.14 fraction and
// saturated to the 31-bit step range.
// ----------------------------------------------------------------------------
module rpwu_scaler (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rpwu_pkg::STEP_W-1:0]   step,
  input  logic [rpwu_pkg::FACT_W-1:0]   factor,
  output logic [rpwu_pkg::STEP_W-1:0]   scaled
);
  import rpwu_pkg::*;

  localparam int PROD_W = STEP_W + FACT_W;
  localparam int SHR_W  = PROD_W - FRAC_SH;

  logic [PROD_W-1:0] prod;
  logic [SHR_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(step) * PROD_W'(factor);
    end
  end

  assign shifted = prod[PROD_W-1:FRAC_SH];
  assign scaled  = (|shifted[SHR_W-1:STEP_W]) ? STEP_SAT : shifted[STEP_W-1:0];

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Rprop weight update core testbench
// Streams load and gradient beats into the core and holds a cycle-free model
// of every entry's weight, step, last move and gradient sign. Each result
// beat is checked field by field against the oldest pending prediction. A
// short directed part covers saturation, backtracking and crossed bounds.
// Random phases then follow with back-pressure and input gaps.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpwu_pkg::*;

  localparam int NUM_ENTRIES = 1024;

  typedef struct {
    logic        [IDX_W-1:0]  idx;
    logic signed [VAL_W-1:0]  weight;
    logic        [STEP_W-1:0] step;
  } weight_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [79:0]          m_axis_tdata;

  // Model of the block's registers and entry store.
  logic        [FACT_W-1:0] increase_q = INCREASE_RST;
  logic        [FACT_W-1:0] decrease_q = DECREASE_RST;
  logic        [STEP_W-1:0] step_min_q = STEP_MIN_RST;
  logic        [STEP_W-1:0] step_max_q = STEP_MAX_RST;
  logic        [STEP_W-1:0] step_ini_q = STEP_INI_RST;
  logic signed [VAL_W-1:0]  weight_tbl [NUM_ENTRIES];
  logic        [STEP_W-1:0] step_tbl   [NUM_ENTRIES];
  logic signed [VAL_W-1:0]  move_tbl   [NUM_ENTRIES];
  logic        [1:0]        sign_tbl   [NUM_ENTRIES];

  weight_result_t pending_results [$];
  int             errors = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;

  rprop_weight_update_core #(
    .NUM_WEIGHTS(NUM_ENTRIES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(2_000_000);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [STEP_W-1:0] scale_step(logic [STEP_W-1:0] st,
                                                   logic [FACT_W-1:0] factor);
    logic [STEP_W+FACT_W-1:0] prod;
    prod = (47'(st) * 47'(factor)) >> FRAC_SH;
    if (prod > 47'(STEP_SAT)) return STEP_SAT;
    return prod[STEP_W-1:0];
  endfunction

  // Applies one accepted beat to the model and queues the result it yields.
  function automatic void apply_rprop(logic op, logic [IDX_W-1:0] idx,
                                      logic signed [VAL_W-1:0] val);
    logic [1:0]        grad_sign;
    logic [1:0]        old_sign;
    logic [STEP_W-1:0] st;
    longint            move;
    longint            sum;
    weight_result_t    res;
    if (op == OP_LOAD) begin
      weight_tbl[idx] = val;
      step_tbl[idx]   = step_ini_q;
      move_tbl[idx]   = '0;
      sign_tbl[idx]   = SIGN_ZERO;
    end else begin
      grad_sign = (val > 0) ? SIGN_POS : ((val < 0) ? SIGN_NEG : SIGN_ZERO);
      old_sign  = sign_tbl[idx];
      st        = step_tbl[idx];
      if ((old_sign == SIGN_POS && grad_sign == SIGN_POS) ||
          (old_sign[1] && grad_sign == SIGN_NEG)) begin
        st = scale_step(st, increase_q);
        if (st > step_max_q) st = step_max_q;
        move = (grad_sign == SIGN_POS) ? -longint'(st) : longint'(st);
        sign_tbl[idx] = grad_sign;
      end else if ((old_sign == SIGN_POS && grad_sign == SIGN_NEG) ||
                   (old_sign[1] && grad_sign == SIGN_POS)) begin
        // Sign change: shrink the step and undo the previous move.
        st = scale_step(st, decrease_q);
        if (st < step_min_q) st = step_min_q;
        move = -longint'(move_tbl[idx]);
        sign_tbl[idx] = SIGN_ZERO;
      end else begin
        if (grad_sign == SIGN_POS) move = -longint'(st);
        else if (grad_sign == SIGN_NEG) move = longint'(st);
        else move = 0;
        sign_tbl[idx] = grad_sign;
      end
      if (move > 64'sd2147483647) move = 64'sd2147483647;
      if (move < -64'sd2147483647) move = -64'sd2147483647;
      move_tbl[idx] = move[VAL_W-1:0];
      step_tbl[idx] = st;
      sum = longint'(weight_tbl[idx]) + move;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      weight_tbl[idx] = sum[VAL_W-1:0];
    end
    res.idx    = idx;
    res.weight = weight_tbl[idx];
    res.step   = step_tbl[idx];
    pending_results.push_back(res);
  endfunction

  task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, val, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_rprop(op, idx, val);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits for every pending result, then for the pipeline to settle.
  task automatic drain();
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [31:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ri)
      REG_INCREASE: increase_q = d[FACT_W-1:0];
      REG_DECREASE: decrease_q = d[FACT_W-1:0];
      REG_STEP_MIN: step_min_q = d[STEP_W-1:0];
      REG_STEP_MAX: step_max_q = d[STEP_W-1:0];
      REG_STEP_INI: step_ini_q = d[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] inc, logic [31:0] dec, logic [31:0] smin,
                            logic [31:0] smax, logic [31:0] sini);
    write_reg(REG_INCREASE, inc);
    write_reg(REG_DECREASE, dec);
    write_reg(REG_STEP_MIN, smin);
    write_reg(REG_STEP_MAX, smax);
    write_reg(REG_STEP_INI, sini);
  endtask

  // Reset values of the registers; weights pushed into both saturation
  // limits, backtracking, zero gradients and same-entry beats back to back.
  task automatic test_reset_defaults();
    send_item(OP_LOAD,   10'd0,    32'h7FFF_FFF0);
    send_item(OP_LOAD,   10'd1023, 32'h8000_0010);
    send_item(OP_LOAD,   10'd5,    32'h0000_0000);
    send_item(OP_UPDATE, 10'd0,    32'hFFFF_FFFF);
    send_item(OP_UPDATE, 10'd0,    32'hFFFF_FF00);
    send_item(OP_UPDATE, 10'd0,    32'h0000_0001);
    send_item(OP_UPDATE, 10'd0,    32'h0000_0001);
    send_item(OP_UPDATE, 10'd0,    32'h0000_0000);
    send_item(OP_UPDATE, 10'd1023, 32'h7FFF_FFFF);
    send_item(OP_UPDATE, 10'd1023, 32'h0000_0001);
    send_item(OP_UPDATE, 10'd1023, 32'h8000_0000);
    send_item(OP_UPDATE, 10'd5,    32'h8000_0000);
    send_item(OP_UPDATE, 10'd5,    32'hFFFF_FFFF);
    stop_sending();
    drain();
  endtask

  // Largest factors and steps: the shrink product overflows 31 bits and
  // the moves reach the full weight range.
  task automatic test_extreme_factors();
    set_config(32'hFFFF, 32'hFFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_LOAD,   10'd512, 32'h0000_0000);
    send_item(OP_UPDATE, 10'd512, 32'h0000_0001);
    send_item(OP_UPDATE, 10'd512, 32'h0000_0001);
    send_item(OP_UPDATE, 10'd512, 32'hFFFF_FFFF);
    stop_sending();
    drain();
  endtask

  // Zero factors with the minimum above the maximum.
  task automatic test_crossed_bounds();
    set_config(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_item(OP_LOAD,   10'd341, 32'h1234_5678);
    send_item(OP_UPDATE, 10'd341, 32'hFFFF_FFFB);
    send_item(OP_UPDATE, 10'd341, 32'hFFFF_FFFB);
    send_item(OP_UPDATE, 10'd341, 32'h0000_0005);
    send_item(OP_UPDATE, 10'd341, 32'hFFFF_FFF9);
    stop_sending();
    drain();
  endtask

  // Mostly gradient runs on a small set of loaded entries so that steps
  // grow, shrink and backtrack; loads and raw gradients are mixed in.
  task automatic test_random_stream(int n_items);
    logic [IDX_W-1:0] pool [16];
    int               dir  [16];
    int               i;
    int               slot;
    int               prev_slot;
    int               r;
    logic [VAL_W-1:0] mag;
    for (i = 0; i < 16; i++) begin
      pool[i] = IDX_W'($urandom_range(NUM_ENTRIES - 1));
      dir[i]  = 0;
      send_item(OP_LOAD, pool[i], $urandom());
    end
    prev_slot = 0;
    for (i = 16; i < n_items; i++) begin
      r    = $urandom_range(99);
      slot = ($urandom_range(99) < 20) ? prev_slot : $urandom_range(15);
      if (r < 8) begin
        pool[slot] = IDX_W'($urandom_range(NUM_ENTRIES - 1));
        dir[slot]  = 0;
        send_item(OP_LOAD, pool[slot], $urandom());
      end else if (r < 14) begin
        send_item(OP_UPDATE, pool[slot], $urandom());
      end else begin
        mag = $urandom() >> $urandom_range(31, 1);
        if (mag == 0) mag = 1;
        r = $urandom_range(99);
        if (r < 5) dir[slot] = 0;
        else if (r < 62 && dir[slot] != 0) dir[slot] = dir[slot];
        else if (dir[slot] != 0) dir[slot] = -dir[slot];
        else dir[slot] = $urandom_range(1) ? 1 : -1;
        if (dir[slot] == 0) send_item(OP_UPDATE, pool[slot], '0);
        else send_item(OP_UPDATE, pool[slot], (dir[slot] > 0) ? mag : -mag);
      end
      prev_slot = slot;
    end
    stop_sending();
    drain();
  endtask

  task automatic moderate_config();
    set_config($urandom_range(16384, 32767), $urandom_range(0, 16383),
               $urandom_range(0, 1000), $urandom_range(32'h1_0000, 32'h400_0000),
               $urandom_range(1, 32'h4_0000));
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    weight_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: index %0d", m_axis_tdata[9:0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[9:0] !== want.idx) begin
          $error("result_index: expected %0d, got %0d", want.idx, m_axis_tdata[9:0]);
          errors++;
        end
        if (m_axis_tdata[41:10] !== want.weight) begin
          $error("new_weight: expected %0d, got %0d", want.weight,
                 $signed(m_axis_tdata[41:10]));
          errors++;
        end
        if (m_axis_tdata[72:42] !== want.step) begin
          $error("new_step: expected %0d, got %0d", want.step, m_axis_tdata[72:42]);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_extreme_factors();
    test_crossed_bounds();

    moderate_config();
    send_idle_pct = 20;
    recv_idle_pct = 88;
    test_random_stream(310);

    set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom() >> 1, $urandom() >> 1, $urandom() >> 1);
    send_idle_pct = 88;
    recv_idle_pct = 20;
    test_random_stream(310);

    moderate_config();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(310);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/rpwu_pkg.sv
design/rpwu_store.sv
design/rpwu_scaler.sv
design/rprop_weight_update_core.sv
tb/tb_top.sv
